// ===== hdl/mace_pkg.sv =====
// Package for the MACE decoder: types, constants and step tables.
package mace_pkg;

    localparam int MaxChannels = 2;
    localparam int ChW = (MaxChannels > 1) ? $clog2(MaxChannels) : 1;
    localparam int QueueDepth = 4;
    localparam logic [15:0] GainUp = 16'sd506;
    localparam logic [15:0] GainDown = 16'sd314;

    typedef enum logic [0:0] {
        REG_STEREO = 1'b0,
        REG_MODE   = 1'b1
    } t_reg_index;

    // One classified byte: channel and the three codes in decode order.
    typedef struct packed {
        logic [ChW-1:0] ch;
        logic           mode3;
        logic [2:0]     c0;
        logic [1:0]     c1;
        logic [2:0]     c2;
    } t_job;

    function automatic logic signed [15:0] adj_wide(input logic [2:0] c);
        case (c)
            3'd0, 3'd7: adj_wide = -16'sd13;
            3'd1, 3'd6: adj_wide = 16'sd8;
            3'd2, 3'd5: adj_wide = 16'sd76;
            default:    adj_wide = 16'sd222;
        endcase
    endfunction

    function automatic logic signed [15:0] adj_narrow(input logic [1:0] c);
        case (c)
            2'd0, 2'd3: adj_narrow = -16'sd18;
            default:    adj_narrow = 16'sd140;
        endcase
    endfunction

    function automatic logic [15:0] steps_wide(input logic [6:0] row, input logic [1:0] col);
        logic [15:0] t [0:511];
        t = '{
 37,116,206,330,39,121,216,346,41,127,225,361,42,132,235,377,
 44,137,245,392,46,144,256,410,48,150,267,428,51,157,280,449,
 53,165,293,470,55,172,306,490,58,179,319,511,60,187,333,534,
 63,195,348,557,66,205,364,583,69,214,380,609,72,223,396,635,
 75,233,414,663,79,244,433,694,82,254,453,725,86,265,472,756,
 90,278,495,792,94,290,516,826,98,303,538,862,102,316,562,901,
 107,331,588,942,112,345,614,983,117,361,641,1027,122,377,670,1074,
 127,394,701,1123,133,411,732,1172,139,430,764,1224,145,449,799,1280,
 152,469,835,1337,159,490,872,1397,166,512,911,1459,173,535,951,1523,
 181,558,993,1590,189,584,1038,1663,197,610,1085,1738,206,637,1133,1815,
 215,665,1183,1895,225,695,1237,1980,235,726,1291,2068,246,759,1349,2161,
 257,792,1409,2257,268,828,1472,2357,280,865,1538,2463,293,903,1606,2572,
 306,944,1678,2688,319,986,1753,2807,334,1030,1832,2933,349,1076,1914,3065,
 364,1124,1999,3202,380,1174,2088,3344,398,1227,2182,3494,415,1281,2278,3649,
 434,1339,2380,3811,453,1398,2486,3982,473,1461,2598,4160,495,1526,2714,4346,
 517,1594,2835,4540,540,1665,2961,4741,564,1740,3093,4953,589,1818,3232,5175,
 615,1898,3375,5405,643,1984,3527,5647,671,2072,3683,5898,701,2164,3848,6161,
 733,2261,4020,6438,766,2362,4199,6724,800,2467,4386,7024,836,2578,4583,7339,
 873,2692,4786,7664,912,2813,5001,8008,952,2938,5223,8364,995,3070,5457,8739,
 1039,3207,5701,9129,1086,3350,5956,9537,1134,3499,6220,9960,1185,3655,6497,10404,
 1238,3818,6788,10869,1293,3989,7091,11355,1351,4166,7407,11861,1411,4352,7738,12390,
 1474,4547,8084,12946,1540,4750,8444,13522,1609,4962,8821,14126,1680,5183,9215,14756,
 1756,5415,9626,15415,1834,5657,10057,16104,1916,5909,10505,16822,2001,6173,10975,17574,
 2091,6448,11463,18356,2184,6736,11974,19175,2282,7037,12510,20032,2383,7351,13068,20926,
 2490,7679,13652,21861,2601,8021,14260,22834,2717,8380,14897,23854,2838,8753,15561,24918,
 2965,9144,16256,26031,3097,9553,16982,27193,3236,9979,17740,28407,3380,10424,18532,29675,
 3531,10890,19359,31000,3688,11375,20222,32382,3853,11883,21125,32767,4025,12414,22069,32767,
 4205,12967,23053,32767,4392,13546,24082,32767,4589,14151,25157,32767,4793,14783,26280,32767,
 5007,15442,27452,32767,5231,16132,28678,32767,5464,16851,29957,32767,5708,17603,31294,32767,
 5963,18389,32691,32767,6229,19210,32767,32767,6507,20067,32767,32767,6797,20963,32767,32767,
 7101,21899,32767,32767,7418,22876,32767,32767,7749,23897,32767,32767,8095,24964,32767,32767,
 8456,26078,32767,32767,8833,27242,32767,32767,9228,28457,32767,32767,9639,29727,32767,32767};
        steps_wide = t[{row, col}];
    endfunction

    function automatic logic [15:0] steps_narrow(input logic [6:0] row, input logic col);
        logic [15:0] t [0:255];
        t = '{
 64,216,67,226,70,236,74,246,77,257,80,268,84,280,88,294,
 92,307,96,321,100,334,104,350,109,365,114,382,119,399,124,416,
 130,434,136,454,142,475,148,495,155,519,162,541,169,564,176,590,
 185,617,193,644,201,673,210,703,220,735,230,767,240,801,251,838,
 262,876,274,914,286,955,299,997,312,1041,326,1089,341,1138,356,1188,
 372,1241,388,1297,406,1354,424,1415,443,1478,462,1544,483,1613,505,1684,
 527,1760,551,1838,576,1921,601,2007,628,2097,656,2190,686,2288,716,2389,
 748,2496,781,2607,816,2724,853,2846,891,2973,930,3104,972,3243,1016,3389,
 1061,3539,1108,3698,1158,3862,1209,4035,1264,4216,1320,4403,1379,4599,1441,4806,
 1505,5019,1572,5244,1642,5477,1715,5722,1792,5978,1872,6245,1955,6522,2043,6813,
 2134,7118,2229,7436,2329,7767,2432,8114,2541,8477,2655,8854,2773,9250,2897,9663,
 3026,10094,3162,10546,3303,11016,3450,11508,3604,12020,3765,12556,3933,13118,4108,13703,
 4292,14315,4483,14953,4683,15621,4892,16318,5111,17046,5339,17807,5577,18602,5826,19433,
 6086,20300,6358,21205,6642,22152,6938,23141,7248,24173,7571,25252,7909,26380,8262,27557,
 8631,28786,9016,30072,9419,31413,9839,32767,10278,32767,10737,32767,11216,32767,11717,32767,
 12240,32767,12786,32767,13356,32767,13953,32767,14576,32767,15226,32767,15906,32767,16615,32767};
        steps_narrow = t[{row, col}];
    endfunction

    // Clip to the level range; below -32768 the low side clips to -32767, while -32768 itself passes.
    function automatic logic signed [15:0] clip_level(input logic signed [16:0] x);
        if (x > 17'sd32767)       clip_level = 16'sh7FFF;
        else if (x < -17'sd32768) clip_level = -16'sh7FFF;
        else                      clip_level = x[15:0];
    endfunction

endpackage

// ===== hdl/mace_front.sv =====
// Front end: accepts bytes, assigns the channel, splits the codes.
module mace_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  logic [7:0]          i_code_byte,
    input  logic                i_stereo,
    input  logic                i_mode3,
    input  logic                i_q_full,
    output logic                o_full,
    output logic                o_q_push,
    output mace_pkg::t_job      o_job
);
    import mace_pkg::*;

    logic [1:0] r_fbc;
    logic [1:0] n_fbc;
    logic [2:0] frame;
    logic       ch;

    always_comb begin
        frame = {1'b0, i_mode3 ? 2'd2 : 2'd1} << i_stereo;
        n_fbc = r_fbc + 2'd1;
        if ({1'b0, n_fbc} >= frame) n_fbc = 2'd0;
        ch = i_stereo & (i_mode3 ? r_fbc[1] : r_fbc[0]);
    end

    assign o_full   = i_q_full;
    assign o_q_push = i_push & ~i_q_full;

    always_comb begin
        o_job.ch    = ChW'(ch);
        o_job.mode3 = i_mode3;
        if (i_mode3) begin
            o_job.c0 = i_code_byte[2:0];
            o_job.c2 = i_code_byte[7:5];
        end else begin
            o_job.c0 = i_code_byte[7:5];
            o_job.c2 = i_code_byte[2:0];
        end
        o_job.c1 = i_code_byte[4:3];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_fbc <= 2'd0;
        else if (o_q_push) r_fbc <= n_fbc;
    end
endmodule

// ===== hdl/mace_queue.sv =====
// Short job queue between front and back end.
module mace_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  mace_pkg::t_job  i_job,
    output logic            o_full,
    input  logic            i_pop,
    output logic            o_empty,
    output mace_pkg::t_job  o_job
);
    import mace_pkg::*;
    localparam int AW = $clog2(QueueDepth);

    t_job        r_mem [QueueDepth];
    logic [AW:0] r_wp, r_rp;

    assign o_empty = (r_wp == r_rp);
    assign o_full  = (r_wp[AW] != r_rp[AW]) && (r_wp[AW-1:0] == r_rp[AW-1:0]);
    assign o_job   = r_mem[r_rp[AW-1:0]];

    always_ff @(posedge i_clk) begin
        if (i_push && !o_full) r_mem[r_wp[AW-1:0]] <= i_job;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= '0;
            r_rp <= '0;
        end else begin
            if (i_push && !o_full) r_wp <= r_wp + 1'b1;
            if (i_pop && !o_empty) r_rp <= r_rp + 1'b1;
        end
    end
endmodule

// ===== hdl/mace_back.sv =====
// Back end: decodes one code per pass, then emits its samples.
module mace_back (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_q_empty,
    input  mace_pkg::t_job        i_job,
    output logic                  o_q_pop,
    input  logic                  i_pop,
    output logic                  o_empty,
    output logic signed [15:0]    o_sample,
    output logic [mace_pkg::ChW-1:0] o_channel_number,
    output logic                  o_last_of_byte
);
    import mace_pkg::*;

    logic signed [15:0] r_pos  [MaxChannels];
    logic signed [15:0] r_gain [MaxChannels];
    logic signed [15:0] r_old  [MaxChannels];
    logic signed [15:0] r_last [MaxChannels];
    logic signed [15:0] r_lvl  [MaxChannels];

    // r_code: code index 0..2; r_mul: 6:1 product pending; r_hold: second half-sample waiting
    logic [1:0]         r_code;
    logic               r_busy;
    logic               r_mul;
    logic signed [15:0] r_mcur;
    logic signed [15:0] r_mf;
    logic               r_ov;
    logic               r_ovl;
    logic signed [15:0] r_ovs;
    logic               r_ovch;
    logic               r_hold;
    logic signed [15:0] r_hs;

    logic [ChW-1:0]     ch;
    logic               out_free;
    logic               stepping;
    logic [2:0]         code;
    logic signed [15:0] pos, adj, npos, step, f, prev, prev2, cur, cl, h, d, s0, s1;
    logic signed [16:0] sum;
    logic signed [16:0] dd;
    logic [15:0]        tv;
    logic               last_code;
    logic signed [31:0] prod;

    assign ch = i_job.ch;
    assign last_code = (r_code == 2'd2);
    assign out_free = !r_ov || (i_pop && !o_empty);
    // Compute a code when the job exists, no product pending, no held sample, output free
    assign stepping = r_busy && !r_mul && !r_hold && out_free;

    always_comb begin
        pos  = r_pos[ch];
        code = 3'd0;
        adj  = '0;
        tv   = '0;
        step = '0;
        unique case (r_code)
            2'd1: begin
                code = {1'b0, i_job.c1};
                adj  = adj_narrow(i_job.c1);
                tv   = steps_narrow(pos[10:4], i_job.c1[1] ? ~i_job.c1[0] : i_job.c1[0]);
                step = i_job.c1[1] ? $signed(-16'sd1 - $signed(tv)) : $signed(tv);
            end
            default: begin
                code = (r_code == 2'd0) ? i_job.c0 : i_job.c2;
                adj  = adj_wide(code);
                tv   = steps_wide(pos[10:4], code[2] ? ~code[1:0] : code[1:0]);
                step = code[2] ? $signed(-16'sd1 - $signed(tv)) : $signed(tv);
            end
        endcase
        npos = pos + adj - (pos >>> 5);
        if (npos < 0) npos = '0;

        f = r_gain[ch];
        prev = r_last[ch];
        if ((prev < 0) == (step < 0))
            f = ($signed({f[15], f}) + 17'sd506 > 17'sd32767) ? 16'sh7FFF : f + $signed(GainUp);
        else
            f = ($signed({f[15], f}) - 17'sd314 < -17'sd32768) ? -16'sh7FFF : f - $signed(GainDown);
        sum = $signed({step[15], step}) + $signed({r_lvl[ch][15], r_lvl[ch]});
        cl  = clip_level(sum);

        prod  = r_mcur * r_mf;
        prev2 = r_old[ch];
        cur   = r_mcur >>> 1;
        dd    = $signed({prev2[15], prev2} - {cur[15], cur}) >>> 2;
        d     = dd[15:0];
        h     = cur;
        s0    = prev + prev2 - d;
        s1    = prev + cur + d;
    end

    assign o_q_pop = r_busy && stepping && last_code && i_job.mode3
                   || r_mul && !r_hold && out_free && last_code;

    assign o_empty = !r_ov;
    assign o_sample = r_ovs;
    assign o_channel_number = r_ovch;
    assign o_last_of_byte = r_ovl;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < MaxChannels; i++) begin
                r_pos[i] <= '0; r_gain[i] <= '0; r_old[i] <= '0;
                r_last[i] <= '0; r_lvl[i] <= '0;
            end
        end else begin
            if (stepping) begin
                r_pos[ch] <= npos;
                if (i_job.mode3) r_lvl[ch] <= cl - (cl >>> 3);
                else begin
                    r_gain[ch] <= f;
                    r_mcur <= cl;
                    r_mf   <= f;
                end
            end
            if (r_mul && !r_hold && out_free) begin
                r_lvl[ch]  <= prod[30:15];
                r_old[ch]  <= prev;
                r_last[ch] <= h;
                r_hs       <= s1;
            end
            // second half-sample keeps the channel of the first; after the last code the job is already popped
            if (stepping && i_job.mode3) begin
                r_ovs <= cl;
                r_ovch <= ch;
                r_ovl <= last_code;
            end else if (r_mul && !r_hold && out_free) begin
                r_ovs <= s0;
                r_ovch <= ch;
                r_ovl <= 1'b0;
            end else if (r_hold && out_free) begin
                r_ovs <= r_hs;
                r_ovl <= last_code;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_code <= '0; r_busy <= 1'b0; r_mul <= 1'b0; r_hold <= 1'b0; r_ov <= 1'b0;
        end else begin
            if (stepping && i_job.mode3) r_ov <= 1'b1;
            else if (r_mul && !r_hold && out_free) r_ov <= 1'b1;
            else if (r_hold && out_free) r_ov <= 1'b1;
            else if (i_pop && !o_empty) r_ov <= 1'b0;

            if (stepping && !i_job.mode3) r_mul <= 1'b1;
            else if (r_mul && !r_hold && out_free) r_mul <= 1'b0;

            if (r_mul && !r_hold && out_free) r_hold <= 1'b1;
            else if (r_hold && out_free) begin
                r_hold <= 1'b0;
                r_code <= last_code ? 2'd0 : r_code + 2'd1;
            end

            if (stepping && i_job.mode3) r_code <= last_code ? 2'd0 : r_code + 2'd1;

            if (o_q_pop) r_busy <= 1'b0;
            else if (!r_busy && !i_q_empty && !r_hold && !r_mul) r_busy <= 1'b1;
        end
    end
endmodule

// ===== hdl/mace_audio_decoder.sv =====
// Top level of the MACE 3:1 / 6:1 audio decoder.
//  channel | direction | handshake          | payload
//  input   | in        | i_push / o_full    | i_code_byte
//  result  | out       | o_empty / i_pop    | o_sample, o_channel_number, o_last_of_byte
//  config  | in        | i_cfg_we           | i_cfg_index, i_cfg_data
// A 3:1 byte is a load of the job from the queue, then one step-table pass
// per code. A 6:1 byte is the load, then per code a table pass, a gain
// multiply and a second half-sample.
// Every back-end cycle that makes a beat waits while the single output register
// is full and not popped; the load cycle and that register set the rate.
// Reset is synchronous, active low, and clears all channel state.
// The 4-entry job queue lets bytes be accepted while the back end stalls on pop.
module mace_audio_decoder (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    output logic               o_full,
    input  logic [7:0]         i_code_byte,
    output logic               o_empty,
    input  logic               i_pop,
    output logic signed [15:0] o_sample,
    output logic               o_channel_number,
    output logic               o_last_of_byte,
    input  logic               i_cfg_we,
    input  logic               i_cfg_index,
    input  logic               i_cfg_data
);
    import mace_pkg::*;

    logic r_stereo, r_mode3;
    logic q_full, q_push, q_empty, q_pop;
    t_job f_job, b_job;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stereo <= 1'b0;
            r_mode3  <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (t_reg_index'(i_cfg_index))
                REG_STEREO: r_stereo <= i_cfg_data;
                REG_MODE:   r_mode3  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    mace_front u_front (
        .i_clk, .i_rst_n, .i_push, .i_code_byte,
        .i_stereo(r_stereo), .i_mode3(r_mode3), .i_q_full(q_full),
        .o_full, .o_q_push(q_push), .o_job(f_job)
    );

    mace_queue u_queue (
        .i_clk, .i_rst_n, .i_push(q_push), .i_job(f_job), .o_full(q_full),
        .i_pop(q_pop), .o_empty(q_empty), .o_job(b_job)
    );

    mace_back u_back (
        .i_clk, .i_rst_n, .i_q_empty(q_empty), .i_job(b_job), .o_q_pop(q_pop),
        .i_pop, .o_empty, .o_sample, .o_channel_number, .o_last_of_byte
    );
endmodule

// ===== hdl/mace_checker.sv =====
// Port checker for the MACE decoder and its bind.
module mace_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_empty,
    input logic        i_pop,
    input logic [15:0] o_sample,
    input logic        o_last_of_byte,
    input logic        o_channel_number
);
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_empty && !i_pop |=> !o_empty && $stable(o_sample))
        else $error("result beat changed while stalled");
    a_rst: assert property (@(posedge i_clk) !i_rst_n |=> o_empty)
        else $error("result after reset");
    a_ch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_empty && !i_pop |=> $stable(o_channel_number) && $stable(o_last_of_byte))
        else $error("result tags changed while stalled");
endmodule

bind mace_audio_decoder mace_checker u_chk (
    .i_clk, .i_rst_n, .o_empty, .i_pop, .o_sample, .o_last_of_byte, .o_channel_number
);
